// File: design/lms_adaptive_fir_filter_assert.svh
// Assertion macros used by the datapath module of the adaptive filter.
`ifndef LMS_ADAPTIVE_FIR_FILTER_ASSERT_SVH
`define LMS_ADAPTIVE_FIR_FILTER_ASSERT_SVH
`ifndef SYNTHESIS
`define LMS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lms: same-cycle check failed");
`define LMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lms: next-cycle check failed");
`else
`define LMS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define LMS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: design/lms_pkg.sv
// Shared types and constants of the LMS adaptive filter.
package lms_pkg;

	localparam int TAP_COUNT_W = 7;
	localparam int STEP_W      = 16;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int CMD_W       = 2;
	localparam int ACC_W       = 64;

	localparam logic [CFG_INDEX_W-1:0] REG_ADAPT_ENABLE = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_STEP_SIZE    = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_TAP_COUNT    = 2'd2;

	localparam logic [CMD_W-1:0] CMD_PROCESS = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_UNITY   = 2'd2;

	localparam logic [STEP_W-1:0]      STEP_SIZE_RESET = 16'd3277;
	localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RESET = 7'd8;

	// One-shot operations that a control word asks of the datapath.
	typedef enum logic [2:0] {
		OP_NOP,
		OP_PUSH,
		OP_CLEAR,
		OP_UNITY,
		OP_YCALC,
		OP_ECALC,
		OP_EMCALC,
		OP_EMIT
	} dp_op_t;

	typedef struct packed {
		logic   take;
		logic   issue;
		logic   upd;
		dp_op_t op;
	} dp_ctrl_t;

	typedef struct packed {
		logic last_tap;
		logic out_free;
	} dp_status_t;

endpackage

// File: design/lms_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lms_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: design/lms_seq.sv
// Microcode sequencer: program ROM, step counter and jump logic.
module lms_seq (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [lms_pkg::CMD_W-1:0]  command,
	input  logic                       adapt_enable,
	input  lms_pkg::dp_status_t        status,
	output lms_pkg::dp_ctrl_t          ctrl
);

	typedef logic [3:0] upc_t;

	typedef enum logic [2:0] {
		CND_NEXT,
		CND_JUMP,
		CND_LOOP,
		CND_NOADAPT,
		CND_WAIT_OUT,
		CND_DISPATCH
	} cond_t;

	typedef struct packed {
		logic            issue;
		logic            upd;
		lms_pkg::dp_op_t op;
		cond_t           cond;
		upc_t            target;
	} uword_t;

	localparam upc_t UPC_IDLE   = 4'd0;
	localparam upc_t UPC_CLEAR  = 4'd1;
	localparam upc_t UPC_UNITY  = 4'd2;
	localparam upc_t UPC_PUSH   = 4'd3;
	localparam upc_t UPC_FLOOP  = 4'd4;
	localparam upc_t UPC_FD1    = 4'd5;
	localparam upc_t UPC_FD2    = 4'd6;
	localparam upc_t UPC_YCALC  = 4'd7;
	localparam upc_t UPC_ECALC  = 4'd8;
	localparam upc_t UPC_EMCALC = 4'd9;
	localparam upc_t UPC_ULOOP  = 4'd10;
	localparam upc_t UPC_UD1    = 4'd11;
	localparam upc_t UPC_UD2    = 4'd12;
	localparam upc_t UPC_EMIT   = 4'd13;

	// The program. Loop steps issue one tap a cycle and repeat until the last tap.
	function automatic uword_t ucode(upc_t pc);
		uword_t w;
		w = '{issue: 1'b0, upd: 1'b0, op: lms_pkg::OP_NOP, cond: CND_NEXT, target: UPC_IDLE};
		unique case (pc)
			UPC_IDLE:   w.cond = CND_DISPATCH;
			UPC_CLEAR: begin
				w.op   = lms_pkg::OP_CLEAR;
				w.cond = CND_JUMP;
			end
			UPC_UNITY: begin
				w.op   = lms_pkg::OP_UNITY;
				w.cond = CND_JUMP;
			end
			UPC_PUSH:   w.op = lms_pkg::OP_PUSH;
			UPC_FLOOP: begin
				w.issue  = 1'b1;
				w.cond   = CND_LOOP;
				w.target = UPC_FLOOP;
			end
			UPC_FD1:    w.op = lms_pkg::OP_NOP;
			UPC_FD2:    w.op = lms_pkg::OP_NOP;
			UPC_YCALC:  w.op = lms_pkg::OP_YCALC;
			UPC_ECALC:  w.op = lms_pkg::OP_ECALC;
			UPC_EMCALC: begin
				w.op     = lms_pkg::OP_EMCALC;
				w.cond   = CND_NOADAPT;
				w.target = UPC_EMIT;
			end
			UPC_ULOOP: begin
				w.issue  = 1'b1;
				w.upd    = 1'b1;
				w.cond   = CND_LOOP;
				w.target = UPC_ULOOP;
			end
			UPC_UD1:    w.op = lms_pkg::OP_NOP;
			UPC_UD2:    w.op = lms_pkg::OP_NOP;
			UPC_EMIT: begin
				w.op   = lms_pkg::OP_EMIT;
				w.cond = CND_WAIT_OUT;
			end
			default:    w.cond = CND_JUMP;
		endcase
		return w;
	endfunction

	upc_t   pc_q;
	upc_t   pc_next;
	uword_t uw;
	upc_t   pc_inc;

	assign uw       = ucode(pc_q);
	assign pc_inc   = upc_t'(pc_q + 1'b1);
	assign in_ready = (uw.cond == CND_DISPATCH);

	always_comb begin
		case (uw.cond)
			CND_NEXT:     pc_next = pc_inc;
			CND_JUMP:     pc_next = uw.target;
			CND_LOOP:     pc_next = status.last_tap ? pc_inc : uw.target;
			CND_NOADAPT:  pc_next = adapt_enable ? pc_inc : uw.target;
			CND_WAIT_OUT: pc_next = status.out_free ? uw.target : pc_q;
			CND_DISPATCH: begin
				pc_next = pc_q;
				if (in_valid) begin
					case (command)
						lms_pkg::CMD_PROCESS: pc_next = UPC_PUSH;
						lms_pkg::CMD_CLEAR:   pc_next = UPC_CLEAR;
						lms_pkg::CMD_UNITY:   pc_next = UPC_UNITY;
						default:              pc_next = UPC_IDLE;
					endcase
				end
			end
			default:      pc_next = UPC_IDLE;
		endcase
	end

	always_comb begin
		ctrl.take  = in_ready && in_valid;
		ctrl.issue = uw.issue;
		ctrl.upd   = uw.upd;
		ctrl.op    = uw.op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= UPC_IDLE;
		end else begin
			pc_q <= pc_next;
		end
	end

endmodule

// File: design/lms_dp.sv
// Datapath: coefficient and delay stores, shared multiply-accumulate, result register.
`include "lms_adaptive_fir_filter_assert.svh"
module lms_dp #(
	parameter int MAX_TAPS     = 64,
	parameter int COEF_WIDTH   = 24,
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  lms_pkg::dp_ctrl_t                      ctrl,
	output lms_pkg::dp_status_t                    status,
	input  logic                                   adapt_enable,
	input  logic [lms_pkg::STEP_W-1:0]             step_size,
	input  logic [lms_pkg::TAP_COUNT_W-1:0]        tap_count,
	input  logic signed [SAMPLE_WIDTH-1:0]         input_sample,
	input  logic signed [SAMPLE_WIDTH-1:0]         desired_sample,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [SAMPLE_WIDTH-1:0]         output_sample,
	output logic signed [SAMPLE_WIDTH:0]           error_sample
);

	localparam int S         = SAMPLE_WIDTH;
	localparam int C         = COEF_WIDTH;
	localparam int KW        = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int ACC_W     = lms_pkg::ACC_W;
	localparam int COEF_FRAC = C - 4;
	localparam int EW        = S + 1;
	localparam int MUW       = lms_pkg::STEP_W + 1;
	localparam int EMW       = EW + MUW;
	localparam int PW        = S + EMW;
	localparam int PRW       = C + S;
	localparam int MW        = (C > EMW) ? C : EMW;
	localparam int UPD_SHIFT = lms_pkg::STEP_W + 2 * (S - 1) - COEF_FRAC;
	localparam int LSH       = (UPD_SHIFT < 0) ? -UPD_SHIFT : 0;
	localparam int DW        = PW + 1 + LSH;
	localparam int SUMW      = ((DW > C) ? DW : C) + 1;

	localparam logic signed [ACC_W:0] HALF_Y   = (ACC_W + 1)'(1) << (COEF_FRAC - 1);
	localparam logic [C-1:0]          COEF_ONE = C'(1) << COEF_FRAC;

	// Input word and delay line head
	logic signed [S-1:0] x_q, d_q;
	logic [KW-1:0]       h_q, ptr_q, k_q, h_new, last_tap;
	logic [MAX_TAPS-1:0] cvalid_q, dvalid_q;

	// Read stage
	logic                v_s1, upd_s1, cv_s1, dv_s1;
	logic [KW-1:0]       kaddr_s1;
	logic [C-1:0]        coef_rd;
	logic [S-1:0]        delay_rd;
	logic signed [C-1:0] cs_s1;
	logic signed [S-1:0] xs_s1;

	// Multiply stage
	logic                   v_s2, upd_s2;
	logic [KW-1:0]          kaddr_s2;
	logic signed [C-1:0]    c_s2;
	logic signed [MW-1:0]   mul_a;
	logic signed [MW+S-1:0] mul_p, prod_s2;

	// Accumulate and result
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W:0]   acc_sum, y_rnd;
	logic signed [S-1:0]     y_q, y_sat;
	logic signed [EW-1:0]    e_q;
	logic signed [EMW-1:0]   em_q;
	logic signed [MUW-1:0]   mu_s;
	logic                    out_valid_q;
	logic signed [S-1:0]     out_y_q;
	logic signed [EW-1:0]    out_e_q;
	logic                    out_free;

	// Coefficient update
	logic signed [PRW-1:0]   fprod;
	logic signed [PW-1:0]    upd_p;
	logic signed [DW-1:0]    delta;
	logic signed [SUMW-1:0]  csum;
	logic [SUMW-C:0]         csum_hi;
	logic [C-1:0]            c_new;
	logic                    coef_we;
	logic [KW-1:0]           coef_waddr;
	logic [C-1:0]            coef_wdata;
	logic                    upd_wr;

	always_comb begin
		if (tap_count == '0) begin
			last_tap = '0;
		end else if (32'(tap_count) > 32'(MAX_TAPS)) begin
			last_tap = KW'(MAX_TAPS - 1);
		end else begin
			last_tap = KW'(tap_count - 1'b1);
		end
	end

	// The delay line is a circular buffer; the newest sample sits at the head.
	assign h_new = (h_q == '0) ? KW'(MAX_TAPS - 1) : KW'(h_q - 1'b1);

	assign out_free        = !out_valid_q || out_ready;
	assign status.last_tap = (k_q == last_tap);
	assign status.out_free = out_free;

	lms_ram #(.WIDTH(C), .DEPTH(MAX_TAPS)) u_coef_ram (
		.clk   (clk),
		.we    (coef_we),
		.waddr (coef_waddr),
		.wdata (coef_wdata),
		.raddr (k_q),
		.rdata (coef_rd)
	);

	lms_ram #(.WIDTH(S), .DEPTH(MAX_TAPS)) u_delay_ram (
		.clk   (clk),
		.we    (ctrl.op == lms_pkg::OP_PUSH),
		.waddr (h_new),
		.wdata (x_q),
		.raddr (ptr_q),
		.rdata (delay_rd)
	);

	// Entries never written since the last clear read as zero.
	assign cs_s1 = cv_s1 ? signed'(coef_rd) : '0;
	assign xs_s1 = dv_s1 ? signed'(delay_rd) : '0;
	assign mul_a = upd_s1 ? MW'(em_q) : MW'(cs_s1);
	assign mul_p = mul_a * xs_s1;

	assign fprod   = prod_s2[PRW-1:0];
	assign acc_sum = (ACC_W + 1)'(acc_q) + (ACC_W + 1)'(fprod);
	assign y_rnd   = ((ACC_W + 1)'(acc_q) + HALF_Y) >>> COEF_FRAC;

	always_comb begin
		if (&y_rnd[ACC_W:S-1] || ~|y_rnd[ACC_W:S-1]) begin
			y_sat = y_rnd[S-1:0];
		end else if (y_rnd[ACC_W]) begin
			y_sat = {1'b1, {(S-1){1'b0}}};
		end else begin
			y_sat = {1'b0, {(S-1){1'b1}}};
		end
	end

	assign upd_p = prod_s2[PW-1:0];

	generate
		if (UPD_SHIFT > 0) begin : g_rshift
			localparam logic signed [PW:0] HALF_U = (PW + 1)'(1) << (UPD_SHIFT - 1);
			logic signed [PW:0] p_rnd;
			assign p_rnd = ((PW + 1)'(upd_p) + HALF_U) >>> UPD_SHIFT;
			assign delta = DW'(p_rnd);
		end else begin : g_lshift
			assign delta = DW'(upd_p) <<< LSH;
		end
	endgenerate

	assign csum    = SUMW'(c_s2) + SUMW'(delta);
	assign csum_hi = csum[SUMW-1:C-1];

	always_comb begin
		if (&csum_hi || ~|csum_hi) begin
			c_new = csum[C-1:0];
		end else if (csum[SUMW-1]) begin
			c_new = {1'b1, {(C-1){1'b0}}};
		end else begin
			c_new = {1'b0, {(C-1){1'b1}}};
		end
	end

	assign upd_wr     = v_s2 && upd_s2;
	assign coef_we    = upd_wr || (ctrl.op == lms_pkg::OP_UNITY);
	assign coef_waddr = upd_wr ? kaddr_s2 : '0;
	assign coef_wdata = upd_wr ? c_new : COEF_ONE;
	assign mu_s       = signed'({1'b0, step_size});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q         <= '0;
			ptr_q       <= '0;
			k_q         <= '0;
			cvalid_q    <= '0;
			dvalid_q    <= '0;
			v_s1        <= 1'b0;
			upd_s1      <= 1'b0;
			v_s2        <= 1'b0;
			upd_s2      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1   <= ctrl.issue;
			upd_s1 <= ctrl.upd;
			v_s2   <= v_s1;
			upd_s2 <= upd_s1;

			if (ctrl.issue) begin
				k_q   <= KW'(k_q + 1'b1);
				ptr_q <= (ptr_q == KW'(MAX_TAPS - 1)) ? '0 : KW'(ptr_q + 1'b1);
			end

			case (ctrl.op)
				lms_pkg::OP_PUSH: begin
					h_q             <= h_new;
					ptr_q           <= h_new;
					k_q             <= '0;
					dvalid_q[h_new] <= 1'b1;
				end
				lms_pkg::OP_ECALC: begin
					ptr_q <= h_q;
					k_q   <= '0;
				end
				lms_pkg::OP_CLEAR: begin
					cvalid_q <= '0;
					dvalid_q <= '0;
				end
				lms_pkg::OP_UNITY: begin
					cvalid_q <= MAX_TAPS'(1);
					dvalid_q <= '0;
				end
				default: begin
				end
			endcase

			if (upd_wr) begin
				cvalid_q[kaddr_s2] <= 1'b1;
			end

			if (ctrl.op == lms_pkg::OP_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.take) begin
			x_q <= input_sample;
			d_q <= desired_sample;
		end
		if (ctrl.issue) begin
			cv_s1    <= cvalid_q[k_q];
			dv_s1    <= dvalid_q[ptr_q];
			kaddr_s1 <= k_q;
		end
		if (v_s1) begin
			prod_s2  <= mul_p;
			c_s2     <= cs_s1;
			kaddr_s2 <= kaddr_s1;
		end

		if (ctrl.op == lms_pkg::OP_PUSH) begin
			acc_q <= '0;
		end else if (v_s2 && !upd_s2) begin
			// The running sum saturates at each step, as a 64-bit accumulator would.
			if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
				acc_q <= acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
			end else begin
				acc_q <= acc_sum[ACC_W-1:0];
			end
		end

		if (ctrl.op == lms_pkg::OP_YCALC) begin
			y_q <= y_sat;
		end
		if (ctrl.op == lms_pkg::OP_ECALC) begin
			e_q <= adapt_enable ? EW'(d_q) - EW'(y_q) : '0;
		end
		if (ctrl.op == lms_pkg::OP_EMCALC) begin
			em_q <= EMW'(e_q) * EMW'(mu_s);
		end
		if (ctrl.op == lms_pkg::OP_EMIT && out_free) begin
			out_y_q <= y_q;
			out_e_q <= e_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign output_sample = out_y_q;
	assign error_sample  = out_e_q;

	`LMS_ASSERT_SAME(a_tap_in_range, clk, arst_n, ctrl.issue, k_q <= last_tap)
	`LMS_ASSERT_NEXT(a_push_marks_head, clk, arst_n, ctrl.op == lms_pkg::OP_PUSH, dvalid_q[h_q])
	`LMS_ASSERT_SAME(a_pipe_drained, clk, arst_n, ctrl.op == lms_pkg::OP_YCALC, !v_s1 && !v_s2)
	`LMS_ASSERT_SAME(a_frozen_error, clk, arst_n, $rose(out_valid_q) && !adapt_enable, out_e_q == '0)

endmodule

// File: design/lms_adaptive_fir_filter.sv
// Top level of the LMS adaptive FIR filter: configuration registers, sequencer and datapath.
// A process word is filtered by the single multiply-accumulate unit, which makes one pass
// over the taps for the filter and, with adaptation on, one for the update, a tap per cycle.
// A new word is taken only once the sequencer is back in idle, after the previous result
// has been handed to the output register.
// Reset is asynchronous and active low; the stores are cleared at once through valid bits.
module lms_adaptive_fir_filter #(
	parameter int MAX_TAPS     = 64,
	parameter int COEF_WIDTH   = 24,
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [lms_pkg::CMD_W-1:0]          command,
	input  logic signed [SAMPLE_WIDTH-1:0]     input_sample,
	input  logic signed [SAMPLE_WIDTH-1:0]     desired_sample,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [SAMPLE_WIDTH-1:0]     output_sample,
	output logic signed [SAMPLE_WIDTH:0]       error_sample,
	input  logic                               cfg_we,
	input  logic [lms_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [lms_pkg::CFG_DATA_W-1:0]     cfg_data
);

	logic                              adapt_q;
	logic [lms_pkg::STEP_W-1:0]        step_q;
	logic [lms_pkg::TAP_COUNT_W-1:0]   taps_q;
	lms_pkg::dp_ctrl_t                 ctrl;
	lms_pkg::dp_status_t               status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adapt_q <= 1'b0;
			step_q  <= lms_pkg::STEP_SIZE_RESET;
			taps_q  <= lms_pkg::TAP_COUNT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lms_pkg::REG_ADAPT_ENABLE: adapt_q <= cfg_data[0];
				lms_pkg::REG_STEP_SIZE:    step_q  <= cfg_data[lms_pkg::STEP_W-1:0];
				lms_pkg::REG_TAP_COUNT:    taps_q  <= cfg_data[lms_pkg::TAP_COUNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	lms_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.adapt_enable (adapt_q),
		.status       (status),
		.ctrl         (ctrl)
	);

	lms_dp #(
		.MAX_TAPS     (MAX_TAPS),
		.COEF_WIDTH   (COEF_WIDTH),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl           (ctrl),
		.status         (status),
		.adapt_enable   (adapt_q),
		.step_size      (step_q),
		.tap_count      (taps_q),
		.input_sample   (input_sample),
		.desired_sample (desired_sample),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.output_sample  (output_sample),
		.error_sample   (error_sample)
	);

endmodule
